@@ hdl/zct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package zct_pkg;

  // Field widths of one item.
  localparam int SAMPLE_W = 32;
  localparam int TIME_W = 48;
  localparam int CROSS_W = TIME_W + 1;
  localparam int IN_DATA_W = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CROSS_W + 7) / 8) * 8;

  // Fraction resolution of the interpolation.
  localparam int FRACTION_BITS = 24;
  localparam int CNT_W = $clog2(FRACTION_BITS);
  localparam int ACC_W = FRACTION_BITS + TIME_W;

  // Direction register codes.
  localparam logic [1:0] DIR_EITHER = 2'd0;
  localparam logic [1:0] DIR_RISING = 2'd1;
  localparam logic [1:0] DIR_FALLING = 2'd2;

  // Program step addresses.
  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_WAIT = 2'd0;
  localparam logic [STEP_W-1:0] STEP_SETUP = 2'd1;
  localparam logic [STEP_W-1:0] STEP_DIVIDE = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT = 2'd3;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NO_INPUT,
    JC_NOT_QUAL,
    JC_MORE,
    JC_OUT_BUSY
  } jump_cond_t;

  // One control word of the program.
  typedef struct packed {
    logic in_ready;
    logic setup;
    logic div_step;
    logic emit;
    jump_cond_t cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Status flags that the datapath returns to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic qualifies;
    logic more;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/zct_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module zct_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire zct_pkg::status_t status,
  output zct_pkg::ctrl_t      ctrl
);
  import zct_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              take_jump;

  // Program table: one control word per step.
  always_comb begin
    ctrl = '0;
    case (pc)
      STEP_WAIT: begin
        ctrl.in_ready = 1'b1;
        ctrl.cond = JC_NO_INPUT;
        ctrl.target = STEP_WAIT;
      end
      STEP_SETUP: begin
        ctrl.setup = 1'b1;
        ctrl.cond = JC_NOT_QUAL;
        ctrl.target = STEP_EMIT;
      end
      STEP_DIVIDE: begin
        ctrl.div_step = 1'b1;
        ctrl.cond = JC_MORE;
        ctrl.target = STEP_DIVIDE;
      end
      STEP_EMIT: begin
        ctrl.emit = 1'b1;
        ctrl.cond = JC_OUT_BUSY;
        ctrl.target = STEP_EMIT;
      end
      default: begin
        ctrl.cond = JC_NEVER;
        ctrl.target = STEP_WAIT;
      end
    endcase
  end

  // Jump condition select.
  always_comb begin
    case (ctrl.cond)
      JC_NEVER:    take_jump = 1'b0;
      JC_NO_INPUT: take_jump = !status.in_valid;
      JC_NOT_QUAL: take_jump = !status.qualifies;
      JC_MORE:     take_jump = status.more;
      JC_OUT_BUSY: take_jump = status.out_busy;
      default:     take_jump = 1'b0;
    endcase
  end

  // Falling through the last step wraps to the wait step.
  assign pc_next = take_jump ? ctrl.target : pc + STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/zct_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module zct_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire zct_pkg::ctrl_t                     ctrl,
  output zct_pkg::status_t                        status,
  input  wire logic                               cfg_wen,
  input  wire logic [1:0]                         cfg_wdata,
  input  wire logic                               in_valid,
  input  wire logic signed [zct_pkg::SAMPLE_W-1:0] in_value,
  input  wire logic [zct_pkg::TIME_W-1:0]         in_time,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_new,
  output logic signed [zct_pkg::CROSS_W-1:0]      out_time
);
  import zct_pkg::*;

  logic [1:0]                 direction;
  logic signed [SAMPLE_W-1:0] cur_value;
  logic [TIME_W-1:0]          cur_time;
  logic signed [SAMPLE_W-1:0] prev_value;
  logic [TIME_W-1:0]          prev_time;
  logic                       have_prev;
  logic signed [CROSS_W-1:0]  last_cross;
  logic                       qual;
  logic [SAMPLE_W-1:0]        rem;
  logic [SAMPLE_W-1:0]        den;
  logic [TIME_W-1:0]          dt;
  logic [ACC_W-1:0]           acc;
  logic [CNT_W-1:0]           cnt;

  logic                       rising;
  logic                       falling;
  logic                       qual_now;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        num_now;
  logic [SAMPLE_W-1:0]        den_now;
  logic [TIME_W-1:0]          dt_now;
  logic [SAMPLE_W:0]          rem_shift;
  logic                       sub_ok;
  logic                       out_busy;
  logic [TIME_W-1:0]          cross_now;

  // Crossing detection against the stored sample.
  always_comb begin
    rising = (prev_value <= 0) && (cur_value > 0);
    falling = (prev_value >= 0) && (cur_value < 0);
    case (direction)
      DIR_EITHER:  qual_now = rising || falling;
      DIR_RISING:  qual_now = rising;
      DIR_FALLING: qual_now = falling;
      default:     qual_now = 1'b0;
    endcase
    qual_now = qual_now && have_prev;
  end

  // Divider operands and step length.
  always_comb begin
    diff = {cur_value[SAMPLE_W-1], cur_value} - {prev_value[SAMPLE_W-1], prev_value};
    den_now = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    num_now = prev_value[SAMPLE_W-1] ? SAMPLE_W'(-prev_value) : SAMPLE_W'(prev_value);
    dt_now = (cur_time > prev_time) ? cur_time - prev_time : '0;
  end

  // One restoring division step; each quotient bit feeds the multiply at once.
  assign rem_shift = {rem, 1'b0};
  assign sub_ok = rem_shift >= {1'b0, den};
  assign cross_now = prev_time + acc[ACC_W-1:FRACTION_BITS];
  assign out_busy = out_valid && !out_ready;

  assign status.in_valid = in_valid;
  assign status.qualifies = qual_now;
  assign status.more = cnt != CNT_W'(FRACTION_BITS - 1);
  assign status.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_EITHER;
      have_prev <= 1'b0;
      prev_value <= '0;
      prev_time <= '0;
      last_cross <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        direction <= cfg_wdata;
      end
      // Take the incoming item.
      if (ctrl.in_ready && in_valid) begin
        cur_value <= in_value;
        cur_time <= in_time;
      end
      // Load the divider and clear the product.
      if (ctrl.setup) begin
        qual <= qual_now;
        rem <= num_now;
        den <= den_now;
        dt <= dt_now;
        acc <= '0;
        cnt <= '0;
      end
      // Quotient bit out, product accumulated most significant bit first.
      if (ctrl.div_step) begin
        rem <= sub_ok ? SAMPLE_W'(rem_shift - {1'b0, den}) : rem_shift[SAMPLE_W-1:0];
        acc <= {acc[ACC_W-2:0], 1'b0} + (sub_ok ? ACC_W'(dt) : '0);
        cnt <= cnt + CNT_W'(1);
      end
      // Release the result and retire the sample.
      if (ctrl.emit && !out_busy) begin
        out_valid <= 1'b1;
        out_new <= qual;
        if (qual) begin
          last_cross <= {1'b0, cross_now};
          out_time <= {1'b0, cross_now};
        end else begin
          out_time <= last_cross;
        end
        prev_value <= cur_value;
        prev_time <= cur_time;
        have_prev <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/zero_crossing_time_interpolator.sv @@
// Steps: the wait step takes an item, the setup step loads the divider; with no qualifying
// crossing the emit step follows, else the divider loop first forms one quotient bit per cycle
// for FRACTION_BITS bits. The emit step holds while the output is stalled. The next item is taken
// after the emit step, while the previous result may still wait in the output register.
// Synchronous active-high reset: no previous sample, crossing time -1, direction 0.
`timescale 1ns / 1ps
`default_nettype none

module zero_crossing_time_interpolator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [1:0]                        cfg_wdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample_value [31:0], sample_time [79:32]
  input  wire logic [zct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // cross_stamp [48:0], zero fill above
  output logic [zct_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // new_crossing [0]
  output logic                                   m_axis_tuser
);
  import zct_pkg::*;

  ctrl_t                     ctrl;
  status_t                   status;
  logic signed [CROSS_W-1:0] out_time;

  zct_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  zct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_value  (s_axis_tdata[SAMPLE_W-1:0]),
    .in_time   (s_axis_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_new   (m_axis_tuser),
    .out_time  (out_time)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tdata = OUT_DATA_W'(unsigned'(out_time));

endmodule

`default_nettype wire
